// ===== rtl/core/mlpbc_pkg.sv =====
package mlpbc_pkg;

  // width of one input word (weights, biases, features)
  localparam int unsigned WordW = 16;
  // weight store is fixed at 256 words, addressed by 8 bits
  localparam int unsigned StoreDepth = 256;
  localparam int unsigned StoreAw = 8;
  // score width and threshold reset value
  localparam int unsigned ScoreW = 32;
  localparam logic signed [WordW-1:0] ThrReset = 16'sd2048;

  // sequencer states
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StHid   = 5'b00010,
    StDrain = 5'b00100,
    StOut   = 5'b01000,
    StWait  = 5'b10000
  } state_e;

  // control tag that travels with each mac step
  typedef struct packed {
    logic valid;
    logic first;
    logic bias;
    logic last;
    logic out_layer;
  } tag_t;

endpackage

// ===== rtl/core/mlp_binary_classifier.sv =====
// channel   | signals                                   | direction
// request   | start_i, busy_o, kind_i, address_i,       | in
//           | value_i, last_i                           |
// result    | done_o, decision_o, score_o               | out
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i      | in
//
// a feature with last runs the forward pass on one shared multiply-accumulate
// unit, one step per cycle except while the pipeline drains between the
// layers and at the end: NUM_HIDDEN*(NUM_FEATURES+1) + NUM_HIDDEN + 1 steps.
// busy_o stays high for the whole pass; the result strobe done_o is high for
// one cycle and cannot be held off. reset is asynchronous, active low, and
// the stores need no clearing pass.
module mlp_binary_classifier #(
  parameter int unsigned NUM_FEATURES = 15,
  parameter int unsigned NUM_HIDDEN   = 10,
  parameter int unsigned DATA_WIDTH   = 16,
  parameter int unsigned FRAC_BITS    = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [7:0]  address_i,
  input  logic signed [15:0] value_i,
  input  logic        last_i,
  output logic        done_o,
  output logic        decision_o,
  output logic signed [31:0] score_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic signed [15:0] cfg_data_i
);

  localparam int unsigned WordW = mlpbc_pkg::WordW;
  localparam int unsigned Kw  = $clog2(NUM_FEATURES + 1);
  localparam int unsigned Jw  = $clog2(NUM_HIDDEN + 1);
  localparam int unsigned Faw = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned Haw = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int unsigned OpW = (DATA_WIDTH > WordW) ? DATA_WIDTH : WordW;
  localparam int unsigned MulW = OpW + WordW;
  localparam int unsigned AccW =
    ((MulW + 7 > WordW + FRAC_BITS + 1) ? MulW + 7 : WordW + FRAC_BITS + 1) + 1;
  localparam logic [7:0] B1Base = 8'((NUM_FEATURES * NUM_HIDDEN) % 256);
  localparam logic [7:0] W2Base = 8'((NUM_FEATURES * NUM_HIDDEN + NUM_HIDDEN) % 256);
  localparam logic [7:0] B2Addr =
    8'((NUM_FEATURES * NUM_HIDDEN + 2 * NUM_HIDDEN) % 256);
  localparam logic signed [AccW-1:0] HMax =
    {{(AccW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [AccW-1:0] SMax = {{(AccW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AccW-1:0] SMin = {{(AccW - 31){1'b1}}, {31{1'b0}}};

  mlpbc_pkg::state_e state_q, state_d;
  logic [Kw-1:0]  k_q, k_d;
  logic [Jw-1:0]  j_q, j_d;
  logic [7:0]     waddr_q, waddr_d;
  logic [Haw-1:0] hw_q, hw_d;
  mlpbc_pkg::tag_t iss, s1_q, s2_q, s3_q;
  logic accept, pass_start, pipe_busy;

  logic signed [WordW-1:0] thr_q;

  // memory ports
  logic             w_we, f_we, h_we;
  logic [7:0]       w_raddr;
  logic [Faw-1:0]   f_raddr;
  logic [Haw-1:0]   h_raddr;
  logic [WordW-1:0] w_rd, f_rd;
  logic [DATA_WIDTH-1:0] h_rd, h_wdata;

  // datapath
  logic signed [OpW-1:0]  opa;
  logic signed [MulW-1:0] mul;
  logic signed [AccW-1:0] prod_d, prod_q, acc_d, acc_q, sh;
  logic signed [AccW-1:0] hid_sat, score_sat;
  logic        done_q;
  logic        decision_q;
  logic signed [31:0] score_q;

  assign accept     = start_i && !busy_o;
  assign pass_start = accept && kind_i && last_i;
  assign busy_o     = (state_q != mlpbc_pkg::StIdle);
  assign pipe_busy  = s1_q.valid || s2_q.valid || s3_q.valid;
  assign cfg_ready_o = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= mlpbc_pkg::ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // issue tag for the current step
  always_comb begin
    iss = '0;
    if (state_q == mlpbc_pkg::StHid) begin
      iss.valid = 1'b1;
      iss.bias  = (k_q == Kw'(NUM_FEATURES));
      iss.first = (k_q == '0);
      iss.last  = iss.bias;
    end else if (state_q == mlpbc_pkg::StOut) begin
      iss.valid     = 1'b1;
      iss.out_layer = 1'b1;
      iss.bias      = (j_q == Jw'(NUM_HIDDEN));
      iss.first     = (j_q == '0);
      iss.last      = iss.bias;
    end
  end

  // read addresses
  always_comb begin
    if (state_q == mlpbc_pkg::StOut) begin
      w_raddr = iss.bias ? B2Addr : 8'(W2Base + 8'(j_q));
    end else begin
      w_raddr = iss.bias ? 8'(B1Base + 8'(j_q)) : waddr_q;
    end
    f_raddr = iss.bias ? '0 : k_q[Faw-1:0];
    h_raddr = iss.bias ? '0 : j_q[Haw-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    waddr_d = waddr_q;
    case (state_q)
      mlpbc_pkg::StIdle: begin
        if (pass_start) begin
          state_d = mlpbc_pkg::StHid;
          k_d     = '0;
          j_d     = '0;
          waddr_d = '0;
        end
      end
      mlpbc_pkg::StHid: begin
        if (iss.bias) begin
          k_d     = '0;
          waddr_d = 8'(j_q + 1'b1);
          if (j_q == Jw'(NUM_HIDDEN - 1)) begin
            j_d     = '0;
            state_d = mlpbc_pkg::StDrain;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d     = k_q + 1'b1;
          waddr_d = 8'(waddr_q + 8'(NUM_HIDDEN));
        end
      end
      mlpbc_pkg::StDrain: begin
        if (!pipe_busy) begin
          state_d = mlpbc_pkg::StOut;
        end
      end
      mlpbc_pkg::StOut: begin
        if (iss.bias) begin
          state_d = mlpbc_pkg::StWait;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      mlpbc_pkg::StWait: begin
        if (!pipe_busy) begin
          state_d = mlpbc_pkg::StIdle;
        end
      end
      default: begin
        state_d = mlpbc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlpbc_pkg::StIdle;
      k_q     <= '0;
      j_q     <= '0;
      waddr_q <= '0;
      hw_q    <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      s3_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      waddr_q <= waddr_d;
      hw_q    <= hw_d;
      s1_q    <= iss;
      s2_q    <= s1_q;
      s3_q    <= s2_q.last ? s2_q : '0;
      done_q  <= s3_q.valid && s3_q.out_layer;
    end
  end

  // stores
  assign w_we = accept && !kind_i;
  assign f_we = accept && kind_i && (address_i < 8'(NUM_FEATURES));

  mlpbc_ram #(
    .Width (WordW),
    .Depth (mlpbc_pkg::StoreDepth)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (address_i),
    .wdata_i (value_i),
    .raddr_i (w_raddr),
    .rdata_o (w_rd)
  );

  mlpbc_ram #(
    .Width (WordW),
    .Depth (NUM_FEATURES)
  ) u_feature_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (address_i[Faw-1:0]),
    .wdata_i (value_i),
    .raddr_i (f_raddr),
    .rdata_o (f_rd)
  );

  mlpbc_ram #(
    .Width (DATA_WIDTH),
    .Depth (NUM_HIDDEN)
  ) u_hidden_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (hw_q),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rd)
  );

  // shared multiplier, bias steps bypass it with a shift
  always_comb begin
    opa = s1_q.out_layer ? OpW'($signed(h_rd)) : OpW'($signed(f_rd));
    mul = opa * $signed(w_rd);
    if (s1_q.bias) begin
      prod_d = AccW'($signed(w_rd)) <<< FRAC_BITS;
    end else begin
      prod_d = AccW'(mul);
    end
  end

  // accumulator
  assign acc_d = (s2_q.first ? AccW'(0) : acc_q) + prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // scaling, relu and saturation of a finished sum
  always_comb begin
    sh = acc_q >>> FRAC_BITS;
    if (sh[AccW-1]) begin
      hid_sat = '0;
    end else if (sh > HMax) begin
      hid_sat = HMax;
    end else begin
      hid_sat = sh;
    end
    if (sh > SMax) begin
      score_sat = SMax;
    end else if (sh < SMin) begin
      score_sat = SMin;
    end else begin
      score_sat = sh;
    end
  end

  assign h_we    = s3_q.valid && !s3_q.out_layer;
  assign h_wdata = DATA_WIDTH'(hid_sat);

  // hidden write index
  always_comb begin
    hw_d = hw_q;
    if (pass_start) begin
      hw_d = '0;
    end else if (h_we) begin
      hw_d = hw_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s3_q.valid && s3_q.out_layer) begin
      score_q    <= 32'(score_sat);
      decision_q <= ($signed(32'(score_sat)) > thr_q);
    end
  end

  assign done_o     = done_q;
  assign score_o    = score_q;
  assign decision_o = decision_q;

  // the pipeline is empty whenever the block is idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !pipe_busy)
    else $error("mac pipeline active while idle");

  // a result only appears at the end of a pass
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == mlpbc_pkg::StWait))
    else $error("result outside the final drain");

  // a last feature starts a pass
  a_pass_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_start |=> busy_o && (state_q == mlpbc_pkg::StHid))
    else $error("pass did not start");

  // hidden activations are written only during the hidden layer
  a_hid_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_we |-> (state_q == mlpbc_pkg::StHid || state_q == mlpbc_pkg::StDrain))
    else $error("hidden write outside the hidden layer");

  // no output layer step is issued before the hidden layer has drained
  a_out_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == mlpbc_pkg::StOut) |-> !pipe_busy)
    else $error("output layer started before hidden writes finished");

endmodule

// ===== rtl/core/mlpbc_ram.sv =====
module mlpbc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
